@@ hdl/bgd_pkg.sv @@
`default_nettype none

package bgd_pkg;

    localparam int COLS      = 5;
    localparam int GRID_W    = 4;
    localparam int DIV_STEPS = 6;

    localparam logic [2:0] BLANK_COL = 3'd7;
    localparam logic [7:0] FRAME_CMD = 8'h40;

    localparam logic [1:0] REG_BAR_TOTAL  = 2'd0;
    localparam logic [1:0] REG_GRID_START = 2'd1;
    localparam logic [1:0] REG_GRID_COUNT = 2'd2;

    typedef struct packed {
        logic [7:0] bar_total;
        logic [2:0] grid_start;
        logic [3:0] grid_count;
    } t_cfg;

    typedef struct packed {
        logic              is_frame;
        logic [GRID_W-1:0] grid;
        logic [2:0]        sub;
        logic [2:0]        per_grid;
        logic [2:0]        level;
    } t_cmd;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WR,
        BK_CMD,
        BK_RD,
        BK_LD
    } t_bk_state;

    function automatic logic [7:0] level_pattern(input logic [2:0] lv);
        logic [7:0] pat;
        case (lv)
            3'd0:    pat = 8'h00;
            3'd1:    pat = 8'h40;
            3'd2:    pat = 8'h60;
            3'd3:    pat = 8'h70;
            3'd4:    pat = 8'h78;
            3'd5:    pat = 8'h7c;
            3'd6:    pat = 8'h7e;
            default: pat = 8'h7f;
        endcase
        return pat;
    endfunction

    // sub-bar that owns a column for a given bars-per-grid, or BLANK_COL
    function automatic logic [2:0] column_owner(input logic [2:0] per_grid,
                                                input logic [2:0] col);
        logic [2:0] own;
        case (per_grid)
            3'd1: own = 3'd0;
            3'd2: begin
                case (col)
                    3'd0, 3'd1: own = 3'd0;
                    3'd3, 3'd4: own = 3'd1;
                    default:    own = BLANK_COL;
                endcase
            end
            3'd3: begin
                case (col)
                    3'd0:    own = 3'd0;
                    3'd2:    own = 3'd1;
                    3'd4:    own = 3'd2;
                    default: own = BLANK_COL;
                endcase
            end
            3'd4:    own = (col == 3'd4) ? BLANK_COL : col;
            3'd5:    own = col;
            default: own = BLANK_COL;
        endcase
        return own;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bgd_ram.sv @@
`default_nettype none

module bgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/bgd_fifo.sv @@
`default_nettype none

module bgd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bgd_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output bgd_pkg::t_cmd      o_cmd,
    output logic               o_empty
);
    import bgd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

endmodule

`default_nettype wire

@@ hdl/bgd_front.sv @@
`default_nettype none

module bgd_front #(
    parameter int GRIDS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bgd_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_opcode,
    input  wire logic [5:0]    i_bar_index,
    input  wire logic [2:0]    i_level,
    output logic               o_push,
    output bgd_pkg::t_cmd      o_cmd,
    input  wire logic          i_full
);
    import bgd_pkg::*;

    t_fe_state  r_state, n_state;
    logic [5:0] r_quo, n_quo;
    logic [2:0] r_rem, n_rem;
    logic [2:0] r_cnt, n_cnt;
    t_cmd       r_cmd, n_cmd;

    logic [7:0] gc1, gc2, gc3, gc4, gc5;
    logic [2:0] per_grid;
    logic [3:0] trial;
    logic       trial_ge;
    logic [6:0] grid_sum;

    // bars per grid = min(bar_total / grid_count, 5) via compares against k * grid_count
    always_comb begin
        gc1 = 8'(i_cfg.grid_count);
        gc2 = {3'd0, i_cfg.grid_count, 1'b0};
        gc4 = {2'd0, i_cfg.grid_count, 2'b00};
        gc3 = gc2 + gc1;
        gc5 = gc4 + gc1;
        if (i_cfg.grid_count == 4'd0) begin
            per_grid = 3'd0;
        end else if (i_cfg.bar_total >= gc5) begin
            per_grid = 3'd5;
        end else if (i_cfg.bar_total >= gc4) begin
            per_grid = 3'd4;
        end else if (i_cfg.bar_total >= gc3) begin
            per_grid = 3'd3;
        end else if (i_cfg.bar_total >= gc2) begin
            per_grid = 3'd2;
        end else if (i_cfg.bar_total >= gc1) begin
            per_grid = 3'd1;
        end else begin
            per_grid = 3'd0;
        end
    end

    // one restoring division step per cycle: bar_index / per_grid
    always_comb begin
        trial    = {r_rem, r_quo[5]};
        trial_ge = (trial >= {1'b0, r_cmd.per_grid});
    end

    always_comb begin
        n_state  = r_state;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        grid_sum = 7'd0;
        o_ready  = 1'b0;
        o_push   = 1'b0;
        case (r_state)
            FE_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd.is_frame = i_opcode;
                    n_cmd.level    = i_level;
                    n_cmd.per_grid = per_grid;
                    n_cmd.grid     = '0;
                    n_cmd.sub      = 3'd0;
                    n_quo          = i_bar_index;
                    n_rem          = 3'd0;
                    n_cnt          = 3'd0;
                    if (i_opcode) begin
                        n_state = FE_PUSH;
                    end else if (per_grid != 3'd0) begin
                        n_state = FE_DIV;
                    end
                end
            end
            FE_DIV: begin
                n_quo = {r_quo[4:0], trial_ge};
                n_rem = trial_ge ? 3'(trial - {1'b0, r_cmd.per_grid}) : trial[2:0];
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'(DIV_STEPS - 1)) begin
                    grid_sum   = 7'(n_quo) + 7'(i_cfg.grid_start);
                    n_cmd.sub  = n_rem;
                    n_cmd.grid = GRID_W'(grid_sum);
                    // grid past the store: drop the write
                    n_state    = (grid_sum < 7'(GRIDS)) ? FE_PUSH : FE_IDLE;
                end
            end
            FE_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = FE_IDLE;
                end
            end
            default: n_state = FE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_cmd <= n_cmd;
    end

    assign o_cmd = r_cmd;

endmodule

`default_nettype wire

@@ hdl/bgd_back.sv @@
`default_nettype none

module bgd_back #(
    parameter int GRIDS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire bgd_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);
    import bgd_pkg::*;

    localparam int STORE = COLS * GRIDS;
    localparam int AW    = $clog2(STORE);

    t_bk_state       r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [2:0]      r_col, n_col;
    logic [AW-1:0]   r_addr, n_addr;
    logic [STORE-1:0] r_vld;
    logic            r_rd_vld;
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;

    logic [2:0]      owner;
    logic [AW-1:0]   wr_addr;
    logic            we;
    logic [7:0]      wdata;
    logic            re;
    logic [7:0]      rdata;
    logic            out_free;
    logic            at_end;

    bgd_ram #(
        .WIDTH (8),
        .DEPTH (STORE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        owner   = column_owner(r_cmd.per_grid, r_col);
        wr_addr = AW'({r_cmd.grid, 2'b00}) + AW'(r_cmd.grid) + AW'(r_col);
        we      = (r_state == BK_WR) && ((owner == BLANK_COL) || (owner == r_cmd.sub));
        wdata   = (owner == BLANK_COL) ? 8'h00 : level_pattern(r_cmd.level);
        re      = (r_state == BK_RD);
        out_free = !r_out_valid || i_ready;
        at_end  = (r_addr == AW'(STORE - 1));
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_col       = r_col;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_col   = 3'd0;
                    n_addr  = '0;
                    n_state = i_cmd.is_frame ? BK_CMD : BK_WR;
                end
            end
            BK_WR: begin
                n_col = r_col + 3'd1;
                if (r_col == 3'(COLS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_CMD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = FRAME_CMD;
                    n_out_last  = 1'b0;
                    n_state     = BK_RD;
                end
            end
            BK_RD: n_state = BK_LD;
            BK_LD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    // never-written entries read as the cleared value
                    n_out_byte  = r_rd_vld ? rdata : 8'h00;
                    n_out_last  = at_end;
                    if (at_end) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_addr  = r_addr + AW'(1);
                        n_state = BK_RD;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (we) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_col      <= n_col;
        r_addr     <= n_addr;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        if (re) begin
            r_rd_vld <= r_vld[r_addr];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

@@ hdl/bar_graph_display_renderer.sv @@
// Set-bar item: the front accepts it, divides bar_index by bars per grid and queues it;
//   the back pops it and writes the five columns of its grid while the front takes more.
// Frame item: the command byte (0x40) goes out first; the 40 store bytes follow,
//   each through a registered store read, then the output register.
// Reset (synchronous, active low) returns registers to 16/0/8, clears all per-entry valid
//   bits so the store reads as zeros at once, and empties the command queue and output.
`default_nettype none

module bar_graph_display_renderer #(
    parameter int GRIDS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [5:0]  i_bar_index,
    input  wire logic [2:0]  i_level,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bgd_pkg::*;

    logic [7:0] r_bar_total;
    logic [2:0] r_grid_start;
    logic [3:0] r_grid_count;
    t_cfg       cfg;
    logic       cfg_wr;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    t_cmd       q_in;
    t_cmd       q_out;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_total  <= 8'd16;
            r_grid_start <= 3'd0;
            r_grid_count <= 4'd8;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BAR_TOTAL:  r_bar_total  <= pwdata[7:0];
                REG_GRID_START: r_grid_start <= pwdata[2:0];
                REG_GRID_COUNT: r_grid_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BAR_TOTAL:  prdata = 32'(r_bar_total);
            REG_GRID_START: prdata = 32'(r_grid_start);
            REG_GRID_COUNT: prdata = 32'(r_grid_count);
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = '{bar_total: r_bar_total, grid_start: r_grid_start, grid_count: r_grid_count};

    bgd_front #(
        .GRIDS (GRIDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_bar_index (i_bar_index),
        .i_level     (i_level),
        .o_push      (q_push),
        .o_cmd       (q_in),
        .i_full      (q_full)
    );

    bgd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    bgd_back #(
        .GRIDS (GRIDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_cmd      (q_out),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

@@ hdl/bgd_checker.sv @@
`default_nettype none

module bgd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_last,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);
    import bgd_pkg::*;

    // output comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output changed");

    // right after the last transfer of a frame, the output is idle or opens a new frame
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last
        |=> !o_valid || (o_out_byte == FRAME_CMD && !o_last))
        else $error("frame did not restart with the command byte");

    // a write to bar_total reads back its value on the next cycle at the same address
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[3:2] == REG_BAR_TOTAL
        |=> (paddr != $past(paddr)) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("bar_total readback mismatch");

    // configuration registers never drive upper read bits
    a_cfg_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite |-> prdata[31:8] == 24'd0 && pready)
        else $error("unexpected upper read data");

endmodule

bind bar_graph_display_renderer bgd_checker u_bgd_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import bgd_pkg::*;

    localparam int GRIDS          = 8;
    localparam int STORE_BYTES    = COLS * GRIDS;
    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 16;

    localparam logic       OP_SET_BAR = 1'b0;
    localparam logic       OP_FRAME   = 1'b1;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_opcode    = 1'b0;
    logic [5:0]  i_bar_index = 6'd0;
    logic [2:0]  i_level     = 3'd0;
    logic        i_ready     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = 4'd0;
    logic [31:0] pwdata      = 32'd0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block: display contents and layout registers
    logic [7:0]  shadow_store [STORE_BYTES];
    logic [7:0]  cfg_total;
    logic [2:0]  cfg_start;
    logic [3:0]  cfg_count;

    t_frame_byte pending_bytes [$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;
    int          hold_asks   = 0;

    bar_graph_display_renderer #(
        .GRIDS(GRIDS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_bar_index (i_bar_index),
        .i_level     (i_level),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [5:0] rand_index();
        if ($urandom_range(0, 4) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 39));
    endfunction

    // column pattern: 'lv' rows lit from the top of a 7-row column
    function automatic logic [7:0] fill_pattern(input logic [2:0] lv);
        logic [15:0] w;
        w = 16'h007f << (3'd7 - lv);
        return w[7:0] & 8'h7f;
    endfunction

    // owning sub-bar per column, column 0 in the low bits
    function automatic logic [14:0] owner_row(input int per_grid);
        logic [14:0] row;
        case (per_grid)
            1:       row = {5{3'd0}};
            2:       row = {3'd1, 3'd1, BLANK_COL, 3'd0, 3'd0};
            3:       row = {3'd2, BLANK_COL, 3'd1, BLANK_COL, 3'd0};
            4:       row = {BLANK_COL, 3'd3, 3'd2, 3'd1, 3'd0};
            default: row = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
        endcase
        return row;
    endfunction

    function automatic void place_bar(input logic [5:0] idx, input logic [2:0] lv);
        int         per_grid;
        int         grid;
        int         sub;
        int         col;
        logic [14:0] row;
        logic [2:0]  owner;
        if (cfg_count == 4'd0)
            return;
        per_grid = int'(cfg_total) / int'(cfg_count);
        if (per_grid > COLS)
            per_grid = COLS;
        if (per_grid == 0)
            return;
        grid = int'(idx) / per_grid + int'(cfg_start);
        sub  = int'(idx) % per_grid;
        if (grid >= GRIDS)
            return;
        row = owner_row(per_grid);
        for (col = 0; col < COLS; col++) begin
            owner = row[col*3 +: 3];
            if (owner == BLANK_COL)
                shadow_store[grid*COLS + col] = 8'h00;
            else if (int'(owner) == sub)
                shadow_store[grid*COLS + col] = fill_pattern(lv);
        end
    endfunction

    function automatic void expect_frame();
        int k;
        pending_bytes.push_back({FRAME_CMD, 1'b0});
        for (k = 0; k < STORE_BYTES; k++)
            pending_bytes.push_back({shadow_store[k], k == STORE_BYTES - 1});
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_BAR_TOTAL:  return {24'd0, cfg_total};
            REG_GRID_START: return {29'd0, cfg_start};
            REG_GRID_COUNT: return {28'd0, cfg_count};
            default:        return 32'd0;
        endcase
    endfunction

    function automatic void note_reg_write(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_BAR_TOTAL:  cfg_total = val[7:0];
            REG_GRID_START: cfg_start = val[2:0];
            REG_GRID_COUNT: cfg_count = val[3:0];
            default: ;
        endcase
    endfunction

    // output side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin : rx_side
        int hold_seen;
        int rx_stall_left;
        if (hold_asks != hold_seen) begin
            hold_seen     = hold_asks;
            rx_stall_left = HOLD_CYCLES;
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
            rx_stall_left = pick_gap();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_out
        t_frame_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected frame byte %h (last %b)", o_out_byte, o_last);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, o_out_byte);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("bar_graph_display_renderer test failed");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_item(input logic op, input logic [5:0] idx, input logic [2:0] lv);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_bar_index <= idx;
        i_level     <= lv;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (op == OP_FRAME)
            expect_frame();
        else
            place_bar(idx, lv);
    endtask

    task automatic set_bar(input logic [5:0] idx, input logic [2:0] lv);
        send_item(OP_SET_BAR, idx, lv);
    endtask

    // a frame closes each phase, so once its bytes are in the block is idle
    task automatic finish_phase();
        send_item(OP_FRAME, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write, then read back through a second transfer
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        note_reg_write(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (idx != REG_UNUSED && prdata !== reg_value(idx)) begin
            $error("prdata: expected %h, got %h", reg_value(idx), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits carry junk half the time; the registers must drop it
    task automatic set_layout(input logic [7:0] total, input logic [2:0] start,
                              input logic [3:0] count);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        write_reg(REG_BAR_TOTAL, {junk[31:8], total});
        write_reg(REG_GRID_START, {junk[31:3], start});
        write_reg(REG_GRID_COUNT, {junk[31:4], count});
    endtask

    task automatic test_reset_frame();
        send_item(OP_FRAME, 6'h3f, 3'h7);
        finish_phase();
    endtask

    // reset layout: 16 bars over 8 grids, two per grid
    task automatic test_default_layout();
        set_bar(6'd0, 3'd7);
        set_bar(6'd1, 3'd1);
        set_bar(6'd15, 3'd7);
        set_bar(6'd16, 3'd5);
        set_bar(6'd3, 3'd0);
        finish_phase();
    endtask

    task automatic test_layout_sweep();
        set_layout(8'd255, 3'd0, 4'd1);     // capped at five per grid
        set_bar(6'd39, 3'd6);
        set_bar(6'd0, 3'd3);
        set_bar(6'd40, 3'd7);               // lands past the last grid
        finish_phase();
        set_layout(8'd4, 3'd5, 4'd1);
        set_bar(6'd5, 3'd2);
        finish_phase();
        set_layout(8'd3, 3'd7, 4'd1);
        set_bar(6'd2, 3'd4);
        set_bar(6'd3, 3'd7);
        finish_phase();
        set_layout(8'd8, 3'd0, 4'd8);
        set_bar(6'd7, 3'd7);
        set_bar(6'd3, 3'd0);
        finish_phase();
    endtask

    task automatic test_dropped_writes();
        set_layout(8'd16, 3'd0, 4'd0);      // no grids
        set_bar(6'd2, 3'd7);
        finish_phase();
        set_layout(8'd3, 3'd0, 4'd4);       // fewer bars than grids
        set_bar(6'd0, 3'd7);
        finish_phase();
        set_layout(8'd10, 3'd2, 4'd2);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        set_bar(6'd9, 3'd6);
        finish_phase();
    endtask

    // output held off while input keeps coming: the command path must fill and stall
    task automatic test_backpressure();
        int n;
        tx_steady = 1'b1;
        hold_asks++;
        send_item(OP_FRAME, rand_index(), 3'($urandom_range(0, 7)));
        for (n = 0; n < 30; n++) begin
            if (n % 10 == 9)
                send_item(OP_FRAME, rand_index(), 3'($urandom_range(0, 7)));
            else
                set_bar(rand_index(), 3'($urandom_range(0, 7)));
        end
        tx_steady = 1'b0;
        finish_phase();
    endtask

    task automatic random_layout(input int phase);
        int total;
        int count;
        int start;
        count = $urandom_range(1, 8);
        start = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0;
        if ($urandom_range(0, 3) == 0) begin
            total = $urandom_range(1, 255);
            count = $urandom_range(0, 8);
        end else begin
            total = count * $urandom_range(1, 5) + $urandom_range(0, count - 1);
        end
        if (phase == 0) begin
            total = 255;
            start = 0;
            count = 8;
        end else if (phase == 1) begin
            total = 1;
            start = 7;
            count = 1;
        end
        set_layout(8'(total), 3'(start), 4'(count));
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++) begin
            random_layout(phase);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 25; n++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_FRAME, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
                else
                    set_bar(rand_index(), 3'($urandom_range(0, 7)));
            end
            finish_phase();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        foreach (shadow_store[k])
            shadow_store[k] = 8'h00;
        cfg_total = 8'd16;
        cfg_start = 3'd0;
        cfg_count = 4'd8;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_frame();
        test_default_layout();
        test_layout_sweep();
        test_dropped_writes();
        test_backpressure();
        test_random_traffic();
        if (fail_count == 0)
            $display("bar_graph_display_renderer test passed");
        else
            $display("bar_graph_display_renderer test failed");
        $finish;
    end

endmodule
